>>> hdl/swsk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swsk_pkg;

  // Field widths
  localparam int unsigned TURN_W = 16;   // turn rate, Q8.8
  localparam int unsigned ANG_W  = 15;   // steering angle, Q2.13
  localparam int unsigned SPD_W  = 16;   // wheel speed, Q8.8
  localparam int unsigned LEN_W  = 16;   // geometry registers, Q4.12

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRONT_LENGTH = 2'd0,
    REG_TRACK_WIDTH  = 2'd1,
    REG_WHEEL_RADIUS = 2'd2
  } cfg_reg_e;

  localparam logic [LEN_W-1:0] FRONT_LENGTH_RST = 16'd2417;
  localparam logic [LEN_W-1:0] TRACK_WIDTH_RST  = 16'd2048;

  // Internal datapath widths
  localparam int unsigned CORD_W  = 32;  // CORDIC x, y, z in Q2.30
  localparam int unsigned ZSH     = 17;  // Q2.13 -> Q2.30
  localparam int unsigned TWOL_W  = LEN_W + 1;
  localparam int unsigned KC_W    = 33;  // w * 2L
  localparam int unsigned KB_W    = 32;  // w * B
  localparam int unsigned TERM_W  = 64;  // products and their sum/difference
  localparam int unsigned FRAC_SH = 30;
  localparam int unsigned HI_W    = TERM_W - 1 - FRAC_SH;  // magnitude >> 30
  localparam int unsigned NUM_W   = HI_W + 1;               // plus rounding offset
  localparam int unsigned QUO_W   = 17;                     // quotient bits, one per stage

  localparam int unsigned ATAN_ENTRIES = 20;

  typedef logic signed [TURN_W-1:0] turn_t;
  typedef logic signed [ANG_W-1:0]  angle_t;
  typedef logic signed [SPD_W-1:0]  speed_t;
  typedef logic signed [CORD_W-1:0] cord_t;

  localparam angle_t ANGLE_LIMIT = 15'sd12868;
  localparam cord_t  CORDIC_GAIN = 32'sd652032874;

  localparam logic [QUO_W-1:0] POS_LIMIT = 17'd32767;
  localparam logic [QUO_W-1:0] NEG_LIMIT = 17'd32768;
  localparam speed_t SPEED_MAX = 16'sh7FFF;
  localparam speed_t SPEED_MIN = 16'sh8000;

  // atan(2^-i) in Q2.30
  localparam cord_t ATAN_Q30 [ATAN_ENTRIES] = '{
    32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159, 32'sd67021687,
    32'sd33543516,  32'sd16775851,  32'sd8388437,   32'sd4194283,   32'sd2097149,
    32'sd1048576,   32'sd524288,    32'sd262144,    32'sd131072,    32'sd65536,
    32'sd32768,     32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048
  };

endpackage

`default_nettype wire

>>> hdl/swsk_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input item channel
interface swsk_item_if import swsk_pkg::*; ();
  logic   valid;
  logic   ready;
  turn_t  turn_rate;
  angle_t steer_angle;

  modport source (output valid, output turn_rate, output steer_angle, input ready);
  modport sink   (input valid, input turn_rate, input steer_angle, output ready);
endinterface

// Result channel
interface swsk_result_if import swsk_pkg::*; ();
  logic   valid;
  logic   ready;
  speed_t left_wheel_speed;
  speed_t right_wheel_speed;
  logic   clipped;

  modport source (output valid, output left_wheel_speed, output right_wheel_speed,
                  output clipped, input ready);
  modport sink   (input valid, input left_wheel_speed, input right_wheel_speed,
                  input clipped, output ready);
endinterface

`default_nettype wire

>>> hdl/steered_wheel_speed_kinematics_unit.sv
// Stages in order: entry, CORDIC, products, sum/difference, magnitude, divider, result.
// One item per cycle unless stalled; one CORDIC iteration and one quotient bit per stage.
// A stalled result freezes every stage; nothing is dropped or repeated.
// Reset (async, active low) clears all valid bits and loads front length 2417
// and track width 2048; datapath registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module steered_wheel_speed_kinematics_unit import swsk_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 14
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  swsk_item_if.sink                  item_i,
  swsk_result_if.source              result_o
);

  localparam int unsigned NC = CORDIC_STEPS;

  // ---------------------------------------------------------------------------
  // Configuration registers (wheel radius cancels, so it is not stored)
  logic [LEN_W-1:0] front_length_q;
  logic [LEN_W-1:0] track_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_length_q <= FRONT_LENGTH_RST;
      track_width_q  <= TRACK_WIDTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FRONT_LENGTH: front_length_q <= cfg_data_i[LEN_W-1:0];
        REG_TRACK_WIDTH:  track_width_q  <= cfg_data_i[LEN_W-1:0];
        REG_WHEEL_RADIUS: ;  // no effect on results
        default:          ;
      endcase
    end
  end

  // Zero length reads as one; 2L feeds the multiplier and the divider
  logic [LEN_W-1:0]  len;
  logic [TWOL_W-1:0] twol;
  assign len  = (front_length_q == '0) ? LEN_W'(1) : front_length_q;
  assign twol = {len, 1'b0};

  // ---------------------------------------------------------------------------
  // Pipeline control: every stage moves when the result register can take data
  logic en;
  logic acc;
  logic res_valid_q;

  assign en           = !res_valid_q || result_o.ready;
  assign item_i.ready = en;
  assign acc          = item_i.valid && en;

  logic [NC:0]    cv_q;     // entry + CORDIC stages
  logic           pv_q;     // products
  logic           av_q;     // sum / difference
  logic           bv_q;     // magnitude
  logic [QUO_W:0] dv_q;     // divider entry + quotient stages

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q        <= '0;
      pv_q        <= 1'b0;
      av_q        <= 1'b0;
      bv_q        <= 1'b0;
      dv_q        <= '0;
      res_valid_q <= 1'b0;
    end else if (en) begin
      cv_q        <= {cv_q[NC-1:0], acc};
      pv_q        <= cv_q[NC];
      av_q        <= pv_q;
      bv_q        <= av_q;
      dv_q        <= {dv_q[QUO_W-1:0], bv_q};
      res_valid_q <= dv_q[QUO_W];
    end
  end

  // ---------------------------------------------------------------------------
  // Entry stage: clamp angle, scale to Q2.30, form w*2L and w*B
  cord_t                   cx_q  [NC+1];
  cord_t                   cy_q  [NC+1];
  cord_t                   cz_q  [NC+1];
  logic signed [KC_W-1:0]  ckc_q [NC+1];
  logic signed [KB_W-1:0]  ckb_q [NC+1];

  angle_t                  ang_c;
  logic signed [KC_W-1:0]  kc_d;
  logic signed [KB_W-1:0]  kb_d;

  always_comb begin
    if (item_i.steer_angle > ANGLE_LIMIT) begin
      ang_c = ANGLE_LIMIT;
    end else if (item_i.steer_angle < -ANGLE_LIMIT) begin
      ang_c = -ANGLE_LIMIT;
    end else begin
      ang_c = item_i.steer_angle;
    end
    kc_d = KC_W'(item_i.turn_rate) * KC_W'($signed({1'b0, twol}));
    kb_d = KB_W'(item_i.turn_rate) * KB_W'($signed({1'b0, track_width_q}));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q[0]  <= CORDIC_GAIN;
      cy_q[0]  <= '0;
      cz_q[0]  <= {ang_c, {ZSH{1'b0}}};
      ckc_q[0] <= kc_d;
      ckb_q[0] <= kb_d;
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC rotation, one iteration per stage
  for (genvar gi = 0; gi < NC; gi++) begin : g_cordic
    cord_t xs, ys, x_d, y_d, z_d;

    always_comb begin
      xs = cx_q[gi] >>> gi;
      ys = cy_q[gi] >>> gi;
      if (!cz_q[gi][CORD_W-1]) begin
        x_d = cx_q[gi] - ys;
        y_d = cy_q[gi] + xs;
        z_d = cz_q[gi] - ATAN_Q30[gi];
      end else begin
        x_d = cx_q[gi] + ys;
        y_d = cy_q[gi] - xs;
        z_d = cz_q[gi] + ATAN_Q30[gi];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cx_q[gi+1]  <= x_d;
        cy_q[gi+1]  <= y_d;
        cz_q[gi+1]  <= z_d;
        ckc_q[gi+1] <= ckc_q[gi];
        ckb_q[gi+1] <= ckb_q[gi];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Product stage: w*2L*cos and w*B*sin
  logic signed [KC_W+CORD_W-1:0] cprod;
  logic signed [KB_W+CORD_W-1:0] sprod;
  logic signed [TERM_W-1:0]      pc_q, ps_q;

  assign cprod = (KC_W+CORD_W)'(ckc_q[NC]) * (KC_W+CORD_W)'(cx_q[NC]);
  assign sprod = (KB_W+CORD_W)'(ckb_q[NC]) * (KB_W+CORD_W)'(cy_q[NC]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      pc_q <= cprod[TERM_W-1:0];
      ps_q <= sprod[TERM_W-1:0];
    end
  end

  // Numerators, lane 0 left and lane 1 right
  logic signed [TERM_W-1:0] an_q [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      an_q[0] <= pc_q - ps_q;
      an_q[1] <= pc_q + ps_q;
    end
  end

  // Magnitude, drop the 30 fraction bits of the numerator
  logic [TERM_W-1:0] mag   [2];
  logic [HI_W-1:0]   bhi_q [2];
  logic [1:0]        bneg_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag[l] = an_q[l][TERM_W-1] ? -an_q[l] : an_q[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        bhi_q[l]  <= mag[l][TERM_W-2:FRAC_SH];
        bneg_q[l] <= an_q[l][TERM_W-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Divider entry: add L for rounding, detect quotients too large for QUO_W bits
  logic [QUO_W-1:0] drem_q [QUO_W+1][2];
  logic [QUO_W-1:0] dlo_q  [QUO_W+1][2];
  logic [QUO_W-1:0] dq_q   [QUO_W+1][2];
  logic [1:0]       dneg_q [QUO_W+1];
  logic [1:0]       dovf_q [QUO_W+1];

  logic [NUM_W-1:0] nsum [2];
  logic [1:0]       ovf_d;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      nsum[l]  = {1'b0, bhi_q[l]} + NUM_W'(len);
      ovf_d[l] = nsum[l][NUM_W-1:QUO_W] >= twol;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        drem_q[0][l] <= nsum[l][NUM_W-1:QUO_W];
        dlo_q[0][l]  <= nsum[l][QUO_W-1:0];
        dq_q[0][l]   <= '0;
      end
      dneg_q[0] <= bneg_q;
      dovf_q[0] <= ovf_d;
    end
  end

  // Restoring division by 2L, one quotient bit per stage, MSB first
  for (genvar gj = 0; gj < QUO_W; gj++) begin : g_div
    localparam int unsigned K = QUO_W - 1 - gj;

    logic [QUO_W:0]   t     [2];
    logic [QUO_W:0]   dif   [2];
    logic [1:0]       ge;
    logic [QUO_W-1:0] rem_d [2];
    logic [QUO_W-1:0] q_d   [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        t[l]     = {drem_q[gj][l], dlo_q[gj][l][K]};
        dif[l]   = t[l] - {1'b0, twol};
        ge[l]    = t[l] >= {1'b0, twol};
        rem_d[l] = ge[l] ? dif[l][QUO_W-1:0] : t[l][QUO_W-1:0];
        q_d[l]   = dq_q[gj][l];
        q_d[l][K] = ge[l];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          drem_q[gj+1][l] <= rem_d[l];
          dlo_q[gj+1][l]  <= dlo_q[gj][l];
          dq_q[gj+1][l]   <= q_d[l];
        end
        dneg_q[gj+1] <= dneg_q[gj];
        dovf_q[gj+1] <= dovf_q[gj];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sign, saturation and result register
  speed_t           spd_d [2];
  logic [1:0]       sat_d;
  logic [QUO_W-1:0] qn    [2];
  logic [QUO_W-1:0] qf    [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qf[l] = dq_q[QUO_W][l];
      qn[l] = -qf[l];
      if (dneg_q[QUO_W][l]) begin
        sat_d[l] = dovf_q[QUO_W][l] || (qf[l] > NEG_LIMIT);
        spd_d[l] = sat_d[l] ? SPEED_MIN : speed_t'(qn[l][SPD_W-1:0]);
      end else begin
        sat_d[l] = dovf_q[QUO_W][l] || (qf[l] > POS_LIMIT);
        spd_d[l] = sat_d[l] ? SPEED_MAX : speed_t'(qf[l][SPD_W-1:0]);
      end
    end
  end

  speed_t res_left_q, res_right_q;
  logic   res_clip_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_left_q  <= spd_d[0];
      res_right_q <= spd_d[1];
      res_clip_q  <= |sat_d;
    end
  end

  assign result_o.valid             = res_valid_q;
  assign result_o.left_wheel_speed  = res_left_q;
  assign result_o.right_wheel_speed = res_right_q;
  assign result_o.clipped           = res_clip_q;

endmodule

`default_nettype wire
